/* hdl/lptu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptu_pkg: shared types and helpers for the two-process timestamp unit
// Sizes, entry format, state codes and saturating stamp arithmetic.
// ----------------------------------------------------------------------------
package lptu_pkg;

    // Array depths and stamp width
    localparam int MAX_P1_EVENTS = 8;
    localparam int MAX_P2_EVENTS = 8;
    localparam int STAMP_BITS    = 8;

    // Fixed field widths
    localparam int EV_W  = 3;
    localparam int CNT_W = 4;
    localparam int REL_W = 2;
    localparam int DIF_W = EV_W + 1;
    localparam int RD_W  = $clog2(MAX_P1_EVENTS + MAX_P2_EVENTS + 1);

    // Entry queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Configuration register indexes (word index, paddr[2])
    localparam logic REG_P1_COUNT = 1'b0;
    localparam logic REG_P2_COUNT = 1'b1;

    typedef logic [STAMP_BITS-1:0] stamp_t;

    localparam stamp_t STAMP_MAX = '1;

    // Relation codes as they arrive on the bus
    localparam logic [REL_W-1:0] REL_SEND = 2'b01;
    localparam logic [REL_W-1:0] REL_RECV = 2'b11;

    // Classified operation
    typedef enum logic [1:0] {
        OP_NONE,
        OP_SEND,
        OP_RECV
    } op_t;

    // One queued matrix entry
    typedef struct packed {
        op_t             op;
        logic [EV_W-1:0] p1_idx;
        logic [EV_W-1:0] p2_idx;
        logic            last;
    } entry_t;

    // Back-end sequencer states
    typedef enum logic {
        ST_RUN,
        ST_READ
    } back_state_t;

    // base + d, capped at the stamp maximum
    function automatic stamp_t sat_add(input stamp_t base, input logic [DIF_W-1:0] d);
        logic [STAMP_BITS+DIF_W-1:0] s;
        s = {{DIF_W{1'b0}}, base} + {{STAMP_BITS{1'b0}}, d};
        return (s >= {{DIF_W{1'b0}}, STAMP_MAX}) ? STAMP_MAX : s[STAMP_BITS-1:0];
    endfunction

    // Initial stamp: event index plus one, saturated
    function automatic stamp_t init_stamp(input logic [EV_W-1:0] idx);
        return sat_add('0, {1'b0, idx} + DIF_W'(1));
    endfunction

    // Zero counts as one, anything above the depth counts as the depth
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                     input int depth);
        logic [CNT_W-1:0] r;
        if (c == '0)
        begin
            r = CNT_W'(1);
        end
        else if (c > CNT_W'(depth))
        begin
            r = CNT_W'(depth);
        end
        else
        begin
            r = c;
        end
        return r;
    endfunction

endpackage

/* hdl/lamport_two_process_timestamps_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamport_two_process_timestamps_unit: Lamport clock for two processes
// Top level: APB count registers, entry classifier, entry queue, updater.
// ----------------------------------------------------------------------------
// Matrix entries are taken one per cycle into a four-entry queue; the
// updater retires one queued entry per cycle, raising the target stamp and
// rewriting all later stamps of that process in the same cycle. An entry
// with tlast set starts a readout of p1_event_count + p2_event_count stamps,
// one per cycle unless m_tready stalls, via the output register (P1 first,
// then P2); stamps return to index plus one with the final item. During
// readout the updater takes no entry, so the input side stalls once the
// queue is full. Counts are clamped to 1..8 and should be written only
// while the unit is idle; entries with an index at or beyond its count are
// ignored, and relation code -2 means no relation. Stamps saturate at 255.
// ----------------------------------------------------------------------------
module lamport_two_process_timestamps_unit
    import lptu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Entry stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [2:0] p1_event, [5:3] p2_event, [7:6] zero
    input  logic [1:0]  s_tuser,    // [1:0] relation
    input  logic        s_tlast,    // last_entry
    // Stamp stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [2:0] event_index, [10:3] timestamp, [15:11] zero
    output logic        m_tuser,    // process_id
    output logic        m_tlast     // last_result
);

    logic [CNT_W-1:0] p1_count_reg;
    logic [CNT_W-1:0] p2_count_reg;
    logic [CNT_W-1:0] p1_count;
    logic [CNT_W-1:0] p2_count;
    logic             wr_en;

    logic             push;
    entry_t           push_entry;
    logic             fifo_full;
    logic             pop;
    entry_t           head;
    logic             empty;

    // Register file, word-decoded on paddr[2]
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_count_reg <= CNT_W'(5);
            p2_count_reg <= CNT_W'(3);
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_P1_COUNT: p1_count_reg <= pwdata[CNT_W-1:0];
                REG_P2_COUNT: p2_count_reg <= pwdata[CNT_W-1:0];
                default:      p1_count_reg <= p1_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_P1_COUNT: prdata = {{(32-CNT_W){1'b0}}, p1_count_reg};
            REG_P2_COUNT: prdata = {{(32-CNT_W){1'b0}}, p2_count_reg};
            default:      prdata = '0;
        endcase
    end

    // Effective counts
    assign p1_count = clamp_count(p1_count_reg, MAX_P1_EVENTS);
    assign p2_count = clamp_count(p2_count_reg, MAX_P2_EVENTS);

    lptu_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .p1_count   (p1_count),
        .p2_count   (p2_count),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_entry (push_entry)
    );

    lptu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    lptu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .p1_count (p1_count),
        .p2_count (p2_count),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* hdl/lptu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptu_front: input classifier
// Accepts matrix entries, range-checks the indices against the active
// counts and turns each entry into a send, receive or no-op for the queue.
// ----------------------------------------------------------------------------
module lptu_front
    import lptu_pkg::*;
(
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [2:0] p1_event, [5:3] p2_event, [7:6] zero
    input  logic [REL_W-1:0] s_tuser,   // [1:0] relation
    input  logic             s_tlast,   // last_entry
    input  logic [CNT_W-1:0] p1_count,
    input  logic [CNT_W-1:0] p2_count,
    input  logic             fifo_full,
    output logic             push,
    output entry_t           push_entry
);

    logic [EV_W-1:0] p1_idx;
    logic [EV_W-1:0] p2_idx;
    logic            in_range;

    assign p1_idx = s_tdata[2:0];
    assign p2_idx = s_tdata[5:3];

    // Take an item whenever the queue has room
    assign s_tready = !fifo_full;
    assign push     = s_tvalid && !fifo_full;

    assign in_range = ({1'b0, p1_idx} < p1_count) && ({1'b0, p2_idx} < p2_count);

    // Classify the entry
    always_comb
    begin
        push_entry.p1_idx = p1_idx;
        push_entry.p2_idx = p2_idx;
        push_entry.last   = s_tlast;
        push_entry.op     = OP_NONE;
        if (in_range)
        begin
            case (s_tuser)
                REL_SEND: push_entry.op = OP_SEND;
                REL_RECV: push_entry.op = OP_RECV;
                default:  push_entry.op = OP_NONE;
            endcase
        end
    end

endmodule

/* hdl/lptu_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptu_fifo: entry queue
// Small register queue that decouples the classifier from the updater.
// ----------------------------------------------------------------------------
module lptu_fifo
    import lptu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   empty
);

    entry_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Fill level stays within depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue fill level above depth");
    // Pops only when something is stored
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty queue");
    // Pushes only when there is room
    assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
        else $error("push into full queue");

endmodule

/* hdl/lptu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptu_back: stamp updater and readout sequencer
// Holds both stamp arrays, applies one queued entry per cycle and, after a
// last entry, streams all stamps out and restores the initial values.
// ----------------------------------------------------------------------------
module lptu_back
    import lptu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] p1_count,
    input  logic [CNT_W-1:0] p2_count,
    input  entry_t           head,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [2:0] event_index, [10:3] timestamp, [15:11] zero
    output logic             m_tuser,   // process_id
    output logic             m_tlast    // last_result
);

    back_state_t     state_reg;
    back_state_t     state_next;

    stamp_t          first_reg  [MAX_P1_EVENTS];
    stamp_t          first_next [MAX_P1_EVENTS];
    stamp_t          second_reg  [MAX_P2_EVENTS];
    stamp_t          second_next [MAX_P2_EVENTS];

    logic [RD_W-1:0] rd_cnt_reg;
    logic [RD_W-1:0] rd_cnt_next;
    logic [RD_W-1:0] rd_total;
    logic [RD_W-1:0] rd_off;
    logic            rd_sel_p2;
    logic [EV_W-1:0] rd_idx;
    logic            rd_last;

    logic [EV_W-1:0] addr1;
    logic [EV_W-1:0] addr2;
    stamp_t          rd1;
    stamp_t          rd2;
    stamp_t          cand;
    stamp_t          base;

    logic            load_out;
    logic            do_init;

    logic            out_valid_reg;
    logic            out_pid_reg;
    logic [EV_W-1:0] out_idx_reg;
    stamp_t          out_stamp_reg;
    logic            out_last_reg;

    // Readout position: P1 stamps first, then P2
    assign rd_total  = RD_W'(p1_count) + RD_W'(p2_count);
    assign rd_sel_p2 = (rd_cnt_reg >= RD_W'(p1_count));
    assign rd_off    = rd_sel_p2 ? rd_cnt_reg - RD_W'(p1_count) : rd_cnt_reg;
    assign rd_idx    = rd_off[EV_W-1:0];
    assign rd_last   = (rd_cnt_reg == rd_total - RD_W'(1));

    // One read port per array, shared between update and readout
    assign addr1 = (state_reg == ST_READ) ? rd_idx : head.p1_idx;
    assign addr2 = (state_reg == ST_READ) ? rd_idx : head.p2_idx;
    assign rd1   = first_reg[addr1];
    assign rd2   = second_reg[addr2];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (!empty && head.last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (do_init)
                begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_RUN:  pop      = !empty;
            ST_READ: load_out = !out_valid_reg || m_tready;
            default:
            begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
        do_init = load_out && rd_last;
    end

    // Readout counter
    always_comb
    begin
        rd_cnt_next = rd_cnt_reg;
        if (pop && head.last)
        begin
            rd_cnt_next = '0;
        end
        else if (load_out)
        begin
            rd_cnt_next = rd_cnt_reg + RD_W'(1);
        end
    end

    // Entry update: raise the target stamp, then rewrite all later events
    // of that process as predecessor plus one (closed form base + distance)
    always_comb
    begin
        cand = '0;
        base = '0;
        for (int k = 0; k < MAX_P1_EVENTS; k++)
        begin
            first_next[k] = first_reg[k];
        end
        for (int k = 0; k < MAX_P2_EVENTS; k++)
        begin
            second_next[k] = second_reg[k];
        end
        case (head.op)
            OP_SEND:
            begin
                cand = sat_add(rd1, DIF_W'(1));
                base = (cand > rd2) ? cand : rd2;
                for (int k = 0; k < MAX_P2_EVENTS; k++)
                begin
                    if (EV_W'(k) == head.p2_idx)
                    begin
                        second_next[k] = base;
                    end
                    else if ((EV_W'(k) > head.p2_idx) && (CNT_W'(k) < p2_count))
                    begin
                        second_next[k] = sat_add(base, DIF_W'(k) - {1'b0, head.p2_idx});
                    end
                end
            end
            OP_RECV:
            begin
                cand = sat_add(rd2, DIF_W'(1));
                base = (cand > rd1) ? cand : rd1;
                for (int k = 0; k < MAX_P1_EVENTS; k++)
                begin
                    if (EV_W'(k) == head.p1_idx)
                    begin
                        first_next[k] = base;
                    end
                    else if ((EV_W'(k) > head.p1_idx) && (CNT_W'(k) < p1_count))
                    begin
                        first_next[k] = sat_add(base, DIF_W'(k) - {1'b0, head.p1_idx});
                    end
                end
            end
            default:
            begin
                cand = '0;
                base = '0;
            end
        endcase
    end

    // Control and stamp registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_P1_EVENTS; k++)
            begin
                first_reg[k] <= init_stamp(EV_W'(k));
            end
            for (int k = 0; k < MAX_P2_EVENTS; k++)
            begin
                second_reg[k] <= init_stamp(EV_W'(k));
            end
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (do_init)
            begin
                for (int k = 0; k < MAX_P1_EVENTS; k++)
                begin
                    first_reg[k] <= init_stamp(EV_W'(k));
                end
                for (int k = 0; k < MAX_P2_EVENTS; k++)
                begin
                    second_reg[k] <= init_stamp(EV_W'(k));
                end
            end
            else if (pop)
            begin
                first_reg  <= first_next;
                second_reg <= second_next;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_pid_reg   <= rd_sel_p2;
            out_idx_reg   <= rd_idx;
            out_stamp_reg <= rd_sel_p2 ? rd2 : rd1;
            out_last_reg  <= rd_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_pid_reg;
    assign m_tdata  = {5'b0, out_stamp_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

    // No entry is taken during readout
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == ST_READ) |-> !pop)
        else $error("entry popped during readout");
    // A popped last entry starts a readout
    assert property (@(posedge clk) disable iff (!rst_n) (pop && head.last) |=>
                     (state_reg == ST_READ && rd_cnt_reg == '0))
        else $error("last entry did not start readout");
    // Loading the final readout item returns to entry processing
    assert property (@(posedge clk) disable iff (!rst_n) do_init |=>
                     (state_reg == ST_RUN && out_valid_reg && out_last_reg))
        else $error("readout did not finish cleanly");
    // The final readout item is always a P2 stamp at the top index
    assert property (@(posedge clk) disable iff (!rst_n) (out_valid_reg && out_last_reg) |->
                     (out_pid_reg && (CNT_W'(out_idx_reg) == p2_count - CNT_W'(1))))
        else $error("final readout item is not the last P2 stamp");

endmodule
